// ----- src/sbus_frame_decoder_assert.svh -----
// Assertion macros for the decoder modules; sfd_back is the one that uses them.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef SBUS_FRAME_DECODER_ASSERT_SVH
`define SBUS_FRAME_DECODER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SFD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SFD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/sfd_pkg.sv -----
package sfd_pkg;

    localparam int FRAME_BYTES   = 25;
    localparam int PAYLOAD_BYTES = 11;
    localparam int PAYLOAD_W     = PAYLOAD_BYTES * 8;
    localparam int COUNT_W       = $clog2(FRAME_BYTES + 2);
    localparam int PAY_IDX_W     = $clog2(PAYLOAD_BYTES);
    localparam int CH_W          = 11;
    localparam int OFS_W         = 12;
    localparam int UPD_W         = 16;
    localparam int QUEUE_DEPTH   = 2;
    localparam int CFG_IDX_W     = 2;

    localparam logic [7:0] HEADER_VALUE = 8'h0F;
    localparam logic [7:0] FOOTER_VALUE = 8'h00;

    localparam logic [CH_W-1:0] CHANNEL_MIN_RESET    = 11'd353;
    localparam logic [CH_W-1:0] CHANNEL_MAX_RESET    = 11'd1694;
    localparam logic [CH_W-1:0] CHANNEL_CENTER_RESET = 11'd1024;

    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_MIN    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_MAX    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_CENTER = 2'd2;

    localparam int CH_X      = 0;
    localparam int CH_Y      = 1;
    localparam int CH_PITCH  = 2;
    localparam int CH_YAW    = 3;
    localparam int CH_SPIN   = 5;
    localparam int CH_WEAPON = 6;
    localparam int CH_AIM    = 7;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_BAD_LENGTH = 3'd1,
        ST_BAD_HEADER = 3'd2,
        ST_BAD_FOOTER = 3'd3,
        ST_BAD_RANGE  = 3'd4
    } status_t;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_last;
    } rx_item_t;

    typedef struct packed {
        status_t                  frame_status;
        logic signed [OFS_W-1:0]  stick_x;
        logic signed [OFS_W-1:0]  stick_y;
        logic signed [OFS_W-1:0]  stick_pitch;
        logic signed [OFS_W-1:0]  stick_yaw;
        logic                     spin_mode;
        logic                     shoot_on;
        logic                     reload_on;
        logic                     autoaim_on;
        logic [UPD_W-1:0]         update_count;
    } result_t;

    // One finished frame handed from the byte collector to the decoder.
    typedef struct packed {
        status_t                pre_status;
        logic [PAYLOAD_W-1:0]   payload;
    } job_t;

    typedef struct packed {
        logic [CH_W-1:0] channel_min;
        logic [CH_W-1:0] channel_max;
        logic [CH_W-1:0] channel_center;
    } cfg_t;

    function automatic logic [CH_W-1:0] get_channel(logic [PAYLOAD_W-1:0] payload, int n);
        return payload[CH_W*n +: CH_W];
    endfunction

endpackage

// ----- src/sbus_frame_decoder.sv -----
// SBUS frame decoder. Received bytes enter one per transfer on the byte channel, with
// frame_last set on the final byte of each frame; every frame end yields exactly one
// transfer on the result channel and other bytes yield none. A byte can be taken in every
// cycle while the queue is not full, so the sustained rate is one byte per clock. A byte
// collector counts bytes, keeps the header and payload bytes 1 to 11, and checks length,
// header and footer on the last byte; the finished frame then waits in a small queue
// (QUEUE_DEPTH entries, two by default), and a decoder unpacks the 11-bit channels,
// range-checks channels 0 to 3 and forms the result in its result register. A frame is
// queued as its last byte is taken and decoded when the result register is free. The
// byte channel stalls only while the queue is full, which happens when two more frame
// ends arrive while a finished result waits on a stalled result channel. Stick outputs
// are raw signed offsets from channel_center; scaling them to float is left to the
// consumer. The channel limits are written through the cfg port (index 0 min, 1 max,
// 2 center) and must only be changed while no frame is in flight.
module sbus_frame_decoder #(
    parameter int QUEUE_DEPTH = sfd_pkg::QUEUE_DEPTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            byte_valid,
    output logic                            byte_stall,
    input  sfd_pkg::rx_item_t               byte_data,
    output logic                            result_valid,
    input  logic                            result_stall,
    output sfd_pkg::result_t                result_data,
    input  logic                            cfg_we,
    input  logic [sfd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sfd_pkg::CH_W-1:0]        cfg_data
);
    import sfd_pkg::*;

    cfg_t cfg_reg, cfg_next;
    job_t front_job;
    job_t head_job;
    logic front_push;
    logic queue_full;
    logic head_valid;
    logic head_pop;

    // Configuration registers; writes to unused indexes are dropped.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_CHANNEL_MIN:    cfg_next.channel_min    = cfg_data;
                CFG_CHANNEL_MAX:    cfg_next.channel_max    = cfg_data;
                CFG_CHANNEL_CENTER: cfg_next.channel_center = cfg_data;
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.channel_min    <= CHANNEL_MIN_RESET;
            cfg_reg.channel_max    <= CHANNEL_MAX_RESET;
            cfg_reg.channel_center <= CHANNEL_CENTER_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Byte collector: counts bytes, stores the payload and checks the frame shape.
    sfd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_data  (byte_data),
        .queue_full (queue_full),
        .push       (front_push),
        .job        (front_job)
    );

    // Finished frames wait here so the collector keeps taking bytes.
    sfd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (front_push),
        .push_data  (front_job),
        .full       (queue_full),
        .head_valid (head_valid),
        .head_data  (head_job),
        .pop        (head_pop)
    );

    // Decoder: channel unpacking, range check, switch logic and the result register.
    sfd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .job_valid    (head_valid),
        .job          (head_job),
        .job_pop      (head_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data)
    );

endmodule

// ----- src/sfd_front.sv -----
module sfd_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              byte_valid,
    output logic              byte_stall,
    input  sfd_pkg::rx_item_t byte_data,
    input  logic              queue_full,
    output logic              push,
    output sfd_pkg::job_t     job
);
    import sfd_pkg::*;

    logic [COUNT_W-1:0]   count_reg, count_next;
    logic [7:0]           header_reg, header_next;
    logic [7:0]           payload_reg [PAYLOAD_BYTES];
    logic                 accept;
    logic [PAY_IDX_W-1:0] wr_idx;
    logic [7:0]           header_now;

    assign byte_stall = queue_full;
    assign accept     = byte_valid && !byte_stall;
    assign push       = accept && byte_data.frame_last;
    assign wr_idx     = count_reg[PAY_IDX_W-1:0] - PAY_IDX_W'(1);

    always_comb
    begin
        count_next  = count_reg;
        header_next = header_reg;
        if (accept)
        begin
            if (count_reg == '0)
            begin
                header_next = byte_data.rx_byte;
            end
            if (byte_data.frame_last)
            begin
                count_next = '0;
            end
            else if (count_reg < COUNT_W'(FRAME_BYTES + 1))
            begin
                count_next = count_reg + COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            header_reg <= '0;
        end
        else
        begin
            count_reg  <= count_next;
            header_reg <= header_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && count_reg != '0 && count_reg <= COUNT_W'(PAYLOAD_BYTES))
        begin
            payload_reg[wr_idx] <= byte_data.rx_byte;
        end
    end

    // A one-byte frame carries its header in the current byte.
    assign header_now = (count_reg == '0) ? byte_data.rx_byte : header_reg;

    always_comb
    begin
        for (int i = 0; i < PAYLOAD_BYTES; i++)
        begin
            job.payload[8*i +: 8] = payload_reg[i];
        end
        if (count_reg != COUNT_W'(FRAME_BYTES - 1))
        begin
            job.pre_status = ST_BAD_LENGTH;
        end
        else if (header_now != HEADER_VALUE)
        begin
            job.pre_status = ST_BAD_HEADER;
        end
        else if (byte_data.rx_byte != FOOTER_VALUE)
        begin
            job.pre_status = ST_BAD_FOOTER;
        end
        else
        begin
            job.pre_status = ST_OK;
        end
    end

endmodule

// ----- src/sfd_fifo.sv -----
module sfd_fifo #(
    parameter int DEPTH = sfd_pkg::QUEUE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  sfd_pkg::job_t push_data,
    output logic          full,
    output logic          head_valid,
    output sfd_pkg::job_t head_data,
    input  logic          pop
);
    import sfd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = mem[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- src/sfd_back.sv -----
module sfd_back (
    input  logic             clk,
    input  logic             rst_n,
    input  sfd_pkg::cfg_t    cfg,
    input  logic             job_valid,
    input  sfd_pkg::job_t    job,
    output logic             job_pop,
    output logic             result_valid,
    input  logic             result_stall,
    output sfd_pkg::result_t result_data
);
    import sfd_pkg::*;

    localparam int STICKS = 4;

    logic                    out_valid_reg, out_valid_next;
    result_t                 out_reg, out_next;
    logic                    shoot_reg, shoot_next;
    logic                    reload_reg, reload_next;
    logic [UPD_W-1:0]        counter_reg, counter_next;
    logic [CH_W-1:0]         stick_ch [STICKS];
    logic signed [OFS_W-1:0] stick_ofs [STICKS];
    logic [CH_W-1:0]         spin_ch, weapon_ch, aim_ch;
    logic                    range_ok;
    logic                    weapon_up, weapon_down;
    status_t                 status;

    assign job_pop = job_valid && (!out_valid_reg || !result_stall);

    always_comb
    begin
        range_ok = 1'b1;
        for (int i = 0; i < STICKS; i++)
        begin
            stick_ch[i]  = get_channel(job.payload, CH_X + i);
            stick_ofs[i] = OFS_W'({1'b0, stick_ch[i]} - {1'b0, cfg.channel_center});
            if (stick_ch[i] < cfg.channel_min || stick_ch[i] > cfg.channel_max)
            begin
                range_ok = 1'b0;
            end
        end
    end

    assign spin_ch     = get_channel(job.payload, CH_SPIN);
    assign weapon_ch   = get_channel(job.payload, CH_WEAPON);
    assign aim_ch      = get_channel(job.payload, CH_AIM);
    assign weapon_up   = (weapon_ch == cfg.channel_min);
    assign weapon_down = !weapon_up && (weapon_ch == cfg.channel_max);

    always_comb
    begin
        if (job.pre_status != ST_OK)
        begin
            status = job.pre_status;
        end
        else if (!range_ok)
        begin
            status = ST_BAD_RANGE;
        end
        else
        begin
            status = ST_OK;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        shoot_next     = shoot_reg;
        reload_next    = reload_reg;
        counter_next   = counter_reg;
        if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (job_pop)
        begin
            out_valid_next        = 1'b1;
            out_next              = '0;
            out_next.frame_status = status;
            if (status == ST_OK)
            begin
                if (weapon_up)
                begin
                    shoot_next = 1'b1;
                end
                else if (weapon_down)
                begin
                    reload_next = 1'b1;
                end
                else
                begin
                    shoot_next  = 1'b0;
                    reload_next = 1'b0;
                end
                counter_next         = counter_reg + UPD_W'(1);
                out_next.stick_x     = stick_ofs[CH_X];
                out_next.stick_y     = stick_ofs[CH_Y];
                out_next.stick_pitch = stick_ofs[CH_PITCH];
                out_next.stick_yaw   = stick_ofs[CH_YAW];
                out_next.spin_mode   = (spin_ch == cfg.channel_min);
                out_next.shoot_on    = shoot_next;
                out_next.reload_on   = reload_next;
                out_next.autoaim_on  = (aim_ch == cfg.channel_min);
            end
            out_next.update_count = counter_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            shoot_reg     <= 1'b0;
            reload_reg    <= 1'b0;
            counter_reg   <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            shoot_reg     <= shoot_next;
            reload_reg    <= reload_next;
            counter_reg   <= counter_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign result_valid = out_valid_reg;
    assign result_data  = out_reg;

`include "sbus_frame_decoder_assert.svh"

    `SFD_ASSERT_SAME(a_fail_clears_fields, out_valid_reg && out_reg.frame_status != ST_OK, out_reg.stick_x == '0 && out_reg.stick_y == '0 && out_reg.stick_pitch == '0 && out_reg.stick_yaw == '0 && !out_reg.spin_mode && !out_reg.shoot_on && !out_reg.reload_on && !out_reg.autoaim_on, "failed frame carries nonzero fields")
    `SFD_ASSERT_SAME(a_count_matches, out_valid_reg, out_reg.update_count == counter_reg, "shown update count differs from decode counter")
    `SFD_ASSERT_NEXT(a_good_frame_counts, job_pop && status == ST_OK, counter_reg != $past(counter_reg), "good frame did not advance the decode counter")

endmodule

// ----- sim/sbus_frame_decoder_tb.sv -----
`timescale 1ns / 1ps

module sbus_frame_decoder_tb;

    import sfd_pkg::*;

    // Clock period and run bounds. A frame's result passes the queue and the
    // result register after its last byte is taken, so a handful of quiet
    // cycles is enough to know the block has nothing left in flight.
    localparam int  HALF_PERIOD   = 6;
    localparam int  RESET_CYCLES  = 7;
    localparam int  SETTLE_CYCLES = 6;
    localparam int  TAIL_CYCLES   = 20;
    localparam int  DRAIN_LIMIT   = 5000;
    localparam int  RANDOM_BYTES  = 340;
    localparam int  RANDOM_FRAMES = 12;
    localparam int  PRINT_CAP     = 40;
    localparam time RUN_LIMIT_NS  = 6_000_000;

    // What the driver does with one entry of its plan: send a byte, write a
    // limit register once the block is idle, or just wait for idle.
    typedef enum logic [1:0] {
        PLAN_BYTE,
        PLAN_REG,
        PLAN_DRAIN
    } plan_kind_e;

    typedef struct packed {
        plan_kind_e            kind;
        rx_item_t              item;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CH_W-1:0]       reg_val;
    } plan_t;

    typedef enum logic [1:0] {
        SW_UP,
        SW_DOWN,
        SW_MID
    } sw_pos_e;

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  byte_valid   = 1'b0;
    logic                  byte_stall;
    rx_item_t              byte_data    = '0;
    logic                  result_valid;
    logic                  result_stall = 1'b0;
    result_t               result_data;
    logic                  cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index    = '0;
    logic [CH_W-1:0]       cfg_data     = '0;

    sbus_frame_decoder uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .byte_data    (byte_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // Byte plan filled up front, and the decoded frames still owed by the block.
    plan_t   byte_plan_q [$];
    result_t frame_result_q [$];

    // Shadow of the decoder: limit registers and the frame collector state.
    logic [CH_W-1:0]   lim_min    = CHANNEL_MIN_RESET;
    logic [CH_W-1:0]   lim_max    = CHANNEL_MAX_RESET;
    logic [CH_W-1:0]   lim_center = CHANNEL_CENTER_RESET;
    logic [4:0]        rx_count   = '0;
    logic [7:0]        rx_header  = '0;
    logic [7:0]        rx_payload [PAYLOAD_BYTES];
    logic [7:0]        rx_tail    = '0;
    logic              shoot_latch  = 1'b0;
    logic              reload_latch = 1'b0;
    logic [UPD_W-1:0]  good_decodes = '0;

    // Limits the stimulus generator assumes when it shapes channel values.
    logic [CH_W-1:0]   gen_min    = CHANNEL_MIN_RESET;
    logic [CH_W-1:0]   gen_max    = CHANNEL_MAX_RESET;
    logic [CH_W-1:0]   gen_center = CHANNEL_CENTER_RESET;
    logic [CH_W-1:0]   ch_set [16];

    int bytes_queued   = 0;
    int frames_queued  = 0;
    int bytes_sent     = 0;
    int frames_checked = 0;
    int reg_writes     = 0;
    int err_count      = 0;
    int status_seen [5];
    int quiet_cycles   = 0;
    int gap_left       = 0;
    int burst_left     = 1;

    // ------------------------------------------------------------------
    // Mismatch reporting. Every failure goes through here so it is both
    // counted and, up to a cap, printed on one line.
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (err_count < PRINT_CAP)
            $display("%0t mismatch: %s got %0d expected %0d", $realtime, what, got, want);
        err_count++;
    endtask

    // ------------------------------------------------------------------
    // Predictor. Follows the block one accepted byte at a time and queues
    // the decoded result whenever a byte closes a frame.
    // ------------------------------------------------------------------
    function automatic sw_pos_e switch_pos(input logic [CH_W-1:0] v);
        // Up is tested first, so it wins when the two limits are equal.
        if (v == lim_min)
            return SW_UP;
        if (v == lim_max)
            return SW_DOWN;
        return SW_MID;
    endfunction

    task automatic decode_byte(input rx_item_t it);
        result_t              r;
        status_t              st;
        logic [PAYLOAD_W-1:0] pay;
        logic [CH_W-1:0]      chn [8];
        sw_pos_e              weapon;
        int                   i;

        // The header is the first byte, payload bytes 1 to 11 are stored, and
        // the most recent byte is kept as the candidate footer.
        if (rx_count == 0)
            rx_header = it.rx_byte;
        else if (rx_count <= PAYLOAD_BYTES)
            rx_payload[PAY_IDX_W'(rx_count - 5'd1)] = it.rx_byte;
        rx_tail = it.rx_byte;
        if (rx_count < FRAME_BYTES + 1)
            rx_count++;

        if (it.frame_last)
        begin
            r = '0;
            if (rx_count != FRAME_BYTES)
                st = ST_BAD_LENGTH;
            else if (rx_header != HEADER_VALUE)
                st = ST_BAD_HEADER;
            else if (rx_tail != FOOTER_VALUE)
                st = ST_BAD_FOOTER;
            else
            begin
                st = ST_OK;
                for (i = 0; i < PAYLOAD_BYTES; i++)
                    pay[8*i +: 8] = rx_payload[i];
                for (i = 0; i < 8; i++)
                    chn[i] = pay[CH_W*i +: CH_W];
                // Only the four stick channels are range checked.
                for (i = 0; i < 4; i++)
                    if (chn[i] < lim_min || chn[i] > lim_max)
                        st = ST_BAD_RANGE;
            end
            rx_count = '0;

            if (st == ST_OK)
            begin
                r.stick_x     = {1'b0, chn[CH_X]}     - {1'b0, lim_center};
                r.stick_y     = {1'b0, chn[CH_Y]}     - {1'b0, lim_center};
                r.stick_pitch = {1'b0, chn[CH_PITCH]} - {1'b0, lim_center};
                r.stick_yaw   = {1'b0, chn[CH_YAW]}   - {1'b0, lim_center};
                r.spin_mode   = (switch_pos(chn[CH_SPIN]) == SW_UP);
                r.autoaim_on  = (switch_pos(chn[CH_AIM]) == SW_UP);
                // Shoot and reload latch on their own position and keep their
                // value while the other one is selected; mid clears both.
                weapon = switch_pos(chn[CH_WEAPON]);
                if (weapon == SW_UP)
                    shoot_latch = 1'b1;
                else if (weapon == SW_DOWN)
                    reload_latch = 1'b1;
                else
                begin
                    shoot_latch  = 1'b0;
                    reload_latch = 1'b0;
                end
                r.shoot_on   = shoot_latch;
                r.reload_on  = reload_latch;
                good_decodes = good_decodes + 1'b1;
            end
            r.frame_status = st;
            r.update_count = good_decodes;
            frame_result_q.push_back(r);
        end
    endtask

    task automatic check_result(input result_t got);
        result_t want;

        if (frame_result_q.size() == 0)
        begin
            report_mismatch("result with no frame pending, status",
                            longint'(got.frame_status), -1);
        end
        else
        begin
            want = frame_result_q.pop_front();
            frames_checked++;
            if (want.frame_status <= ST_BAD_RANGE)
                status_seen[want.frame_status]++;
            if (got.frame_status !== want.frame_status)
                report_mismatch("frame_status", longint'(got.frame_status),
                                longint'(want.frame_status));
            if (got.stick_x !== want.stick_x)
                report_mismatch("stick_x", longint'($signed(got.stick_x)),
                                longint'($signed(want.stick_x)));
            if (got.stick_y !== want.stick_y)
                report_mismatch("stick_y", longint'($signed(got.stick_y)),
                                longint'($signed(want.stick_y)));
            if (got.stick_pitch !== want.stick_pitch)
                report_mismatch("stick_pitch", longint'($signed(got.stick_pitch)),
                                longint'($signed(want.stick_pitch)));
            if (got.stick_yaw !== want.stick_yaw)
                report_mismatch("stick_yaw", longint'($signed(got.stick_yaw)),
                                longint'($signed(want.stick_yaw)));
            if (got.spin_mode !== want.spin_mode)
                report_mismatch("spin_mode", longint'(got.spin_mode),
                                longint'(want.spin_mode));
            if (got.shoot_on !== want.shoot_on)
                report_mismatch("shoot_on", longint'(got.shoot_on), longint'(want.shoot_on));
            if (got.reload_on !== want.reload_on)
                report_mismatch("reload_on", longint'(got.reload_on),
                                longint'(want.reload_on));
            if (got.autoaim_on !== want.autoaim_on)
                report_mismatch("autoaim_on", longint'(got.autoaim_on),
                                longint'(want.autoaim_on));
            if (got.update_count !== want.update_count)
                report_mismatch("update_count", longint'(got.update_count),
                                longint'(want.update_count));
        end
    endtask

    // ------------------------------------------------------------------
    // Monitor. Samples both channels and the register port at each rising
    // edge, before the driver's nonblocking updates of that edge land.
    // quiet_cycles counts edges with no activity on any port; the driver
    // uses it to know the block has settled before a register write.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : observe
        if (rst_n)
        begin
            if (result_valid && !result_stall)
                check_result(result_data);
            if (byte_valid && !byte_stall)
                decode_byte(byte_data);
            if (cfg_we)
            begin
                reg_writes++;
                case (cfg_index)
                    CFG_CHANNEL_MIN:    lim_min    = cfg_data;
                    CFG_CHANNEL_MAX:    lim_max    = cfg_data;
                    CFG_CHANNEL_CENTER: lim_center = cfg_data;
                    default: ;
                endcase
            end
            if (byte_valid || result_valid || cfg_we)
                quiet_cycles <= 0;
            else if (quiet_cycles < 1000)
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Driver. Works through the plan in bursts of random length separated by
    // random gaps. A byte on offer is held until a transfer takes it. Plan
    // entries other than bytes wait until no result is owed and the ports
    // have been quiet for a while, which is also how the sender pauses for
    // the block to drain. All outputs get exactly one update per edge.
    // ------------------------------------------------------------------
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(99, 0);
        if (roll < 30)
            return 0;
        if (roll < 94)
            return $urandom_range(8, 1);
        return $urandom_range(40, 20);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : byte_driver
        logic                 nxt_valid;
        rx_item_t             nxt_data;
        logic                 nxt_we;
        logic [CFG_IDX_W-1:0] nxt_idx;
        logic [CH_W-1:0]      nxt_val;
        plan_t                head;

        if (!rst_n)
        begin
            byte_valid <= 1'b0;
            byte_data  <= '0;
            cfg_we     <= 1'b0;
            cfg_index  <= '0;
            cfg_data   <= '0;
            gap_left   = 0;
            burst_left = $urandom_range(60, 1);
        end
        else
        begin
            nxt_valid = byte_valid;
            nxt_data  = byte_data;
            nxt_we    = 1'b0;
            nxt_idx   = cfg_index;
            nxt_val   = cfg_data;
            if (byte_valid && !byte_stall)
                nxt_valid = 1'b0;

            if (!nxt_valid)
            begin
                if (gap_left != 0)
                begin
                    gap_left--;
                end
                else if (byte_plan_q.size() != 0)
                begin
                    head = byte_plan_q[0];
                    if (head.kind == PLAN_BYTE)
                    begin
                        head      = byte_plan_q.pop_front();
                        nxt_valid = 1'b1;
                        nxt_data  = head.item;
                        bytes_sent++;
                        burst_left--;
                        if (burst_left <= 0)
                        begin
                            burst_left = $urandom_range(60, 1);
                            gap_left   = pick_gap();
                        end
                    end
                    else if (!byte_valid && frame_result_q.size() == 0 &&
                             quiet_cycles >= SETTLE_CYCLES)
                    begin
                        // Idle: the register write (if any) goes out now.
                        head = byte_plan_q.pop_front();
                        if (head.kind == PLAN_REG)
                        begin
                            nxt_we  = 1'b1;
                            nxt_idx = head.reg_idx;
                            nxt_val = head.reg_val;
                        end
                    end
                end
            end

            byte_valid <= nxt_valid;
            byte_data  <= nxt_data;
            cfg_we     <= nxt_we;
            cfg_index  <= nxt_idx;
            cfg_data   <= nxt_val;
        end
    end

    // ------------------------------------------------------------------
    // Result sink. Stalls follow a pattern of their own that switches, at the end
    // of each random-length phase, between never stalling, scattered single stalls,
    // and long stall runs that fill the decoder's frame queue and push back
    // on the byte channel.
    // ------------------------------------------------------------------
    int   sink_mode       = 0;
    int   sink_phase_left = 0;
    int   sink_run_left   = 0;
    logic sink_run_level  = 1'b0;

    always @(posedge clk or negedge rst_n)
    begin : result_sink
        logic nxt_stall;

        if (!rst_n)
        begin
            result_stall    <= 1'b0;
            sink_mode       = 0;
            sink_phase_left = 0;
        end
        else
        begin
            if (sink_phase_left == 0)
            begin
                sink_mode       = $urandom_range(2, 0);
                sink_phase_left = $urandom_range(200, 20);
            end
            else
            begin
                sink_phase_left--;
            end
            case (sink_mode)
                0: nxt_stall = 1'b0;
                1: nxt_stall = ($urandom_range(2, 0) == 0);
                default:
                begin
                    if (sink_run_left == 0)
                    begin
                        sink_run_level = ~sink_run_level;
                        sink_run_left  = sink_run_level ? $urandom_range(30, 1)
                                                        : $urandom_range(6, 1);
                    end
                    else
                    begin
                        sink_run_left--;
                    end
                    nxt_stall = sink_run_level;
                end
            endcase
            result_stall <= nxt_stall;
        end
    end

    // ------------------------------------------------------------------
    // Plan building.
    // ------------------------------------------------------------------
    task automatic plan_byte(input logic [7:0] b, input logic last);
        plan_t p;
        p = '0;
        p.kind            = PLAN_BYTE;
        p.item.rx_byte    = b;
        p.item.frame_last = last;
        byte_plan_q.push_back(p);
        bytes_queued++;
        if (last)
            frames_queued++;
    endtask

    task automatic plan_drain();
        plan_t p;
        p      = '0;
        p.kind = PLAN_DRAIN;
        byte_plan_q.push_back(p);
    endtask

    // Writes all three limits; the writes themselves wait for the block to
    // go idle, and the plan always sits on a frame boundary when this runs.
    task automatic plan_limits(input logic [CH_W-1:0] lo, input logic [CH_W-1:0] hi,
                               input logic [CH_W-1:0] mid);
        plan_t p;
        p         = '0;
        p.kind    = PLAN_REG;
        p.reg_idx = CFG_CHANNEL_MIN;
        p.reg_val = lo;
        byte_plan_q.push_back(p);
        p.reg_idx = CFG_CHANNEL_MAX;
        p.reg_val = hi;
        byte_plan_q.push_back(p);
        p.reg_idx = CFG_CHANNEL_CENTER;
        p.reg_val = mid;
        byte_plan_q.push_back(p);
        gen_min    = lo;
        gen_max    = hi;
        gen_center = mid;
    endtask

    task automatic fill_channels(input logic [CH_W-1:0] v);
        int i;
        for (i = 0; i < 16; i++)
            ch_set[i] = v;
    endtask

    // Sends ch_set as an SBUS frame of len bytes: header, 22 packed channel
    // bytes, a flags byte and the footer. Short frames are cut off early;
    // long ones get random filler before the footer.
    task automatic plan_frame(input logic [7:0] hdr, input logic [7:0] ftr, input int len);
        logic [175:0] bits;
        logic [7:0]   fb [FRAME_BYTES];
        int           i;

        for (i = 0; i < 16; i++)
            bits[CH_W*i +: CH_W] = ch_set[i];
        fb[0] = hdr;
        for (i = 0; i < 22; i++)
            fb[1 + i] = bits[8*i +: 8];
        fb[23] = 8'($urandom_range(255, 0));
        fb[24] = ftr;
        if (len <= FRAME_BYTES)
        begin
            for (i = 0; i < len; i++)
                plan_byte(fb[i], i == len - 1);
        end
        else
        begin
            for (i = 0; i < FRAME_BYTES - 1; i++)
                plan_byte(fb[i], 1'b0);
            for (i = 0; i < len - FRAME_BYTES; i++)
                plan_byte(8'($urandom_range(255, 0)), 1'b0);
            plan_byte(ftr, 1'b1);
        end
    endtask

    // Channel values for a random frame, shaped by the limits in force so
    // most frames decode, the switches land on their positions often, and
    // now and then a stick channel falls just outside the limits.
    task automatic random_channels();
        int i;
        int roll;
        for (i = 0; i < 16; i++)
        begin
            if (gen_min <= gen_max && $urandom_range(7, 0) != 0)
                ch_set[i] = CH_W'($urandom_range(gen_max, gen_min));
            else
                ch_set[i] = CH_W'($urandom_range(2047, 0));
        end
        for (i = 0; i < 4; i++)
        begin
            roll = $urandom_range(15, 0);
            if (roll == 0)
                ch_set[i] = gen_min;
            else if (roll == 1)
                ch_set[i] = gen_max;
        end
        for (i = CH_SPIN; i <= CH_AIM; i++)
        begin
            roll = $urandom_range(2, 0);
            if (roll == 0)
                ch_set[i] = gen_min;
            else if (roll == 1)
                ch_set[i] = gen_max;
        end
        if ($urandom_range(9, 0) == 0)
        begin
            i = $urandom_range(3, 0);
            if (gen_min > 0 && $urandom_range(1, 0) == 0)
                ch_set[i] = gen_min - 1'b1;
            else if (gen_max < 2047)
                ch_set[i] = gen_max + 1'b1;
        end
    endtask

    task automatic random_limits();
        logic [CH_W-1:0] lo;
        case ($urandom_range(3, 0))
            0: plan_limits(CH_W'($urandom_range(500, 200)), CH_W'($urandom_range(1900, 1500)),
                           CH_W'($urandom_range(1100, 900)));
            1: plan_limits(11'd0, 11'd2047, CH_W'($urandom_range(2047, 0)));
            2: plan_limits(CH_W'($urandom_range(2047, 0)), CH_W'($urandom_range(2047, 0)),
                           CH_W'($urandom_range(2047, 0)));
            default:
            begin
                lo = CH_W'($urandom_range(1900, 0));
                plan_limits(lo, CH_W'(lo + $urandom_range(100, 0)),
                            CH_W'(lo + $urandom_range(50, 0)));
            end
        endcase
    endtask

    task automatic random_frame();
        int          roll;
        int          n;
        int          k;
        logic [7:0]  hdr;
        logic [7:0]  ftr;

        roll = $urandom_range(99, 0);
        random_channels();
        if (roll < 70)
        begin
            plan_frame(HEADER_VALUE, FOOTER_VALUE, FRAME_BYTES);
        end
        else if (roll < 80)
        begin
            hdr = HEADER_VALUE;
            ftr = FOOTER_VALUE;
            if ($urandom_range(1, 0) == 0)
            begin
                hdr = 8'($urandom_range(255, 0));
                if (hdr == HEADER_VALUE)
                    hdr = hdr ^ 8'h80;
            end
            else
            begin
                ftr = 8'($urandom_range(255, 1));
            end
            plan_frame(hdr, ftr, FRAME_BYTES);
        end
        else if (roll < 90)
        begin
            if ($urandom_range(1, 0) == 0)
                plan_frame(HEADER_VALUE, FOOTER_VALUE, $urandom_range(FRAME_BYTES - 1, 1));
            else
                plan_frame(HEADER_VALUE, FOOTER_VALUE,
                           $urandom_range(FRAME_BYTES + 10, FRAME_BYTES + 1));
        end
        else
        begin
            // Line noise: random bytes with stray frame ends, closed by a
            // frame end so the plan stays on a boundary.
            n = $urandom_range(20, 1);
            for (k = 0; k < n; k++)
                plan_byte(8'($urandom_range(255, 0)),
                          (k == n - 1) || ($urandom_range(7, 0) == 0));
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence: build the whole plan, reset once, then wait for the block to
    // work through it and report.
    // ------------------------------------------------------------------
    initial
    begin : run
        int first_byte;
        int first_frame;
        int since_limits;
        int waited;

        for (int s = 0; s < 5; s++)
            status_seen[s] = 0;
        for (int s = 0; s < PAYLOAD_BYTES; s++)
            rx_payload[s] = '0;

        // Directed frames under the reset limits. The first one is full
        // length, so every payload entry is written before any is decoded.
        fill_channels(11'd1024);
        ch_set[CH_SPIN]   = 11'd1000;
        ch_set[CH_WEAPON] = 11'd1000;
        ch_set[CH_AIM]    = 11'd1000;
        plan_frame(HEADER_VALUE, FOOTER_VALUE, FRAME_BYTES);
        // Sticks on the limits, all switches up.
        ch_set[CH_X]      = 11'd353;
        ch_set[CH_Y]      = 11'd1694;
        ch_set[CH_PITCH]  = 11'd353;
        ch_set[CH_YAW]    = 11'd1694;
        ch_set[CH_SPIN]   = 11'd353;
        ch_set[CH_WEAPON] = 11'd353;
        ch_set[CH_AIM]    = 11'd353;
        plan_frame(HEADER_VALUE, FOOTER_VALUE, FRAME_BYTES);
        // Weapon switch walk: down keeps shoot, mid clears, down, up keeps reload.
        ch_set[CH_WEAPON] = 11'd1694;
        plan_frame(HEADER_VALUE, FOOTER_VALUE, FRAME_BYTES);
        ch_set[CH_WEAPON] = 11'd1000;
        plan_frame(HEADER_VALUE, FOOTER_VALUE, FRAME_BYTES);
        ch_set[CH_WEAPON] = 11'd1694;
        plan_frame(HEADER_VALUE, FOOTER_VALUE, FRAME_BYTES);
        ch_set[CH_WEAPON] = 11'd353;
        plan_frame(HEADER_VALUE, FOOTER_VALUE, FRAME_BYTES);
        // One stick channel out of range at a time, both sides.
        fill_channels(11'd1024);
        ch_set[CH_X] = 11'd352;
        plan_frame(HEADER_VALUE, FOOTER_VALUE, FRAME_BYTES);
        ch_set[CH_X] = 11'd1024;
        ch_set[CH_Y] = 11'd1695;
        plan_frame(HEADER_VALUE, FOOTER_VALUE, FRAME_BYTES);
        ch_set[CH_Y]     = 11'd1024;
        ch_set[CH_PITCH] = 11'd0;
        plan_frame(HEADER_VALUE, FOOTER_VALUE, FRAME_BYTES);
        ch_set[CH_PITCH] = 11'd1024;
        ch_set[CH_YAW]   = 11'd2047;
        plan_frame(HEADER_VALUE, FOOTER_VALUE, FRAME_BYTES);
        // Framing faults, including the check order when several are wrong,
        // a single-byte frame and a long frame that saturates the count.
        fill_channels(11'd1024);
        plan_frame(8'h8F, FOOTER_VALUE, FRAME_BYTES);
        plan_frame(HEADER_VALUE, 8'h04, FRAME_BYTES);
        plan_frame(8'hF0, 8'hFF, FRAME_BYTES);
        plan_frame(HEADER_VALUE, FOOTER_VALUE, FRAME_BYTES - 1);
        plan_frame(HEADER_VALUE, FOOTER_VALUE, FRAME_BYTES + 1);
        plan_frame(HEADER_VALUE, FOOTER_VALUE, FRAME_BYTES + 15);
        plan_frame(HEADER_VALUE, FOOTER_VALUE, 1);
        plan_frame(8'h00, FOOTER_VALUE, FRAME_BYTES - 1);
        // All-ones payload: every channel at 2047.
        fill_channels(11'd2047);
        plan_frame(HEADER_VALUE, FOOTER_VALUE, FRAME_BYTES);
        // Sender holds off until the block has returned every result.
        plan_drain();

        // Widest limits with center at zero, channels at both extremes.
        plan_limits(11'd0, 11'd2047, 11'd0);
        fill_channels(11'd0);
        ch_set[CH_Y]      = 11'd2047;
        ch_set[CH_PITCH]  = 11'd2047;
        ch_set[CH_WEAPON] = 11'd2047;
        ch_set[CH_AIM]    = 11'd2047;
        plan_frame(HEADER_VALUE, FOOTER_VALUE, FRAME_BYTES);
        fill_channels(11'd0);
        plan_frame(HEADER_VALUE, FOOTER_VALUE, FRAME_BYTES);
        // Equal limits: a switch at that value reads as up. Center at top.
        plan_limits(11'd1000, 11'd1000, 11'd2047);
        fill_channels(11'd1000);
        plan_frame(HEADER_VALUE, FOOTER_VALUE, FRAME_BYTES);
        // Inverted limits fail every range check.
        plan_limits(11'd1500, 11'd200, 11'd1024);
        fill_channels(11'd1000);
        plan_frame(HEADER_VALUE, FOOTER_VALUE, FRAME_BYTES);
        plan_limits(CHANNEL_MIN_RESET, CHANNEL_MAX_RESET, CHANNEL_CENTER_RESET);

        // Random traffic with a fresh set of limits every dozen frames or so.
        first_byte   = bytes_queued;
        first_frame  = frames_queued;
        since_limits = 0;
        while ((bytes_queued - first_byte) < RANDOM_BYTES ||
               (frames_queued - first_frame) < RANDOM_FRAMES)
        begin
            if (since_limits >= 12)
            begin
                random_limits();
                since_limits = 0;
            end
            else if ($urandom_range(19, 0) == 0)
            begin
                plan_drain();
            end
            random_frame();
            since_limits++;
        end

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        while (byte_plan_q.size() != 0 || byte_valid)
            @(posedge clk);
        waited = 0;
        while (frame_result_q.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        if (frame_result_q.size() != 0)
            report_mismatch("frames never returned", 0, longint'(frame_result_q.size()));

        $display("Sent %0d bytes and checked %0d frame results over %0d register writes.",
                 bytes_sent, frames_checked, reg_writes);
        $display("Results by status: ok %0d, length %0d, header %0d, footer %0d, range %0d.",
                 status_seen[ST_OK], status_seen[ST_BAD_LENGTH], status_seen[ST_BAD_HEADER],
                 status_seen[ST_BAD_FOOTER], status_seen[ST_BAD_RANGE]);
        if (err_count == 0)
            $display("[sbus_frame_decoder] OK");
        else
            $display("[sbus_frame_decoder] ERROR");
        $finish;
    end

    // Hard stop in case the block hangs a handshake.
    initial
    begin : watchdog
        #(RUN_LIMIT_NS);
        $display("[sbus_frame_decoder] ERROR");
        $finish;
    end

endmodule
